[hdl/hts_pkg.sv]
package hts_pkg;

  localparam int MAX_TAGS     = 256;
  localparam int MAX_EXPLICIT = 32;

  localparam int TAG_W      = 8;
  localparam int TAG_SPACE  = 1 << TAG_W;
  localparam int CNT_W      = $clog2(MAX_EXPLICIT + 1);
  localparam int LIST_IDX_W = (MAX_EXPLICIT > 1) ? $clog2(MAX_EXPLICIT) : 1;
  localparam int STEP_W     = $clog2(MAX_TAGS + 1);

  // A walk of at least TAG_SPACE - 1 steps reaches every ancestor of its start,
  // so it may stop at a node that an earlier walk has already marked.
  localparam bit EARLY_STOP = (MAX_TAGS >= TAG_SPACE - 1);

  localparam logic [2:0] ACT_LOAD      = 3'd0;
  localparam logic [2:0] ACT_ADD       = 3'd1;
  localparam logic [2:0] ACT_REMOVE    = 3'd2;
  localparam logic [2:0] ACT_HAS       = 3'd3;
  localparam logic [2:0] ACT_HAS_EXACT = 3'd4;
  localparam logic [2:0] ACT_CLEAR     = 3'd5;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_DUP     = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic [2:0]       action;
    logic [TAG_W-1:0] tag_id;
    logic [TAG_W-1:0] parent_id;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic decode;
    logic clear_set;
    logic load_parent;
    logic add_commit;
    logic rm_start;
    logic rm_commit;
    logic anc_clear;
    logic tag_fetch;
    logic walk_start;
    logic walk_step;
    logic out_load;
  } hts_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       tag_zero;
    logic       exp_hit;
    logic       full;
    logic       list_done;
    logic       walk_done;
    logic       out_free;
  } hts_stat_t;

endpackage

[hdl/hts_datapath.sv]
module hts_datapath (
  input  logic              clk,
  input  logic              rst,
  input  hts_pkg::in_item_t  in_data,
  input  hts_pkg::hts_cmd_t  cmd,
  output hts_pkg::hts_stat_t stat,
  output logic              out_valid,
  input  logic              out_stall,
  output hts_pkg::out_item_t out_data
);
  import hts_pkg::*;

  in_item_t             item;
  logic [TAG_SPACE-1:0] exp_mark;
  logic [TAG_SPACE-1:0] anc_mark;
  logic [TAG_SPACE-1:0] par_vld;
  logic [TAG_W-1:0]     par_mem [TAG_SPACE];
  logic [LIST_IDX_W-1:0] pos_mem [TAG_SPACE];
  logic [TAG_W-1:0]     list_mem [MAX_EXPLICIT];
  logic [CNT_W-1:0]     cnt;
  logic [CNT_W-1:0]     li;
  logic [STEP_W-1:0]    steps;
  logic [TAG_W-1:0]     par_q;
  logic [LIST_IDX_W-1:0] pos_q;
  logic [TAG_W-1:0]     list_q;
  out_item_t            res;
  out_item_t            res_next;
  logic [LIST_IDX_W-1:0] last_idx;
  logic [LIST_IDX_W-1:0] list_raddr;
  logic [TAG_W-1:0]     par_raddr;
  logic                 exp_hit;
  logic                 anc_hit;
  logic                 full;
  logic                 tag_zero;

  assign exp_hit    = exp_mark[item.tag_id];
  assign anc_hit    = anc_mark[item.tag_id];
  assign full       = (cnt >= CNT_W'(MAX_EXPLICIT));
  assign tag_zero   = (item.tag_id == '0);
  assign last_idx   = LIST_IDX_W'(cnt - CNT_W'(1));
  assign list_raddr = cmd.rm_start ? last_idx : li[LIST_IDX_W-1:0];
  assign par_raddr  = cmd.walk_step ? par_q : list_q;

  assign stat.action    = item.action;
  assign stat.tag_zero  = tag_zero;
  assign stat.exp_hit   = exp_hit;
  assign stat.full      = full;
  assign stat.list_done = (li == cnt);
  assign stat.walk_done = (par_q == '0) || (steps == STEP_W'(MAX_TAGS)) ||
                          (EARLY_STOP && anc_mark[par_q]);
  assign stat.out_free  = !out_valid || !out_stall;

  always_comb begin
    res_next.found  = 1'b0;
    res_next.status = ST_OK;
    if (item.action == ACT_CLEAR) begin
      res_next.status = ST_OK;
    end else if (item.action > ACT_CLEAR) begin
      res_next.status = ST_OK;
    end else if (tag_zero) begin
      res_next.status = ST_INVALID;
    end else begin
      case (item.action)
        ACT_ADD: begin
          if (exp_hit) begin
            res_next.status = ST_DUP;
          end else if (full) begin
            res_next.status = ST_FULL;
          end
        end
        ACT_REMOVE: begin
          if (exp_hit) begin
            res_next.found = 1'b1;
          end else begin
            res_next.status = ST_DUP;
          end
        end
        ACT_HAS:       res_next.found = exp_hit | anc_hit;
        ACT_HAS_EXACT: res_next.found = exp_hit;
        default:       res_next.found = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_mark  <= '0;
      anc_mark  <= '0;
      par_vld   <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clear_set) begin
        exp_mark <= '0;
        anc_mark <= '0;
        cnt      <= '0;
      end
      if (cmd.load_parent) begin
        par_vld[item.tag_id] <= 1'b1;
      end
      if (cmd.add_commit) begin
        exp_mark[item.tag_id] <= 1'b1;
        cnt                   <= cnt + CNT_W'(1);
      end
      if (cmd.rm_start) begin
        exp_mark[item.tag_id] <= 1'b0;
      end
      if (cmd.rm_commit) begin
        cnt <= cnt - CNT_W'(1);
      end
      if (cmd.anc_clear) begin
        anc_mark <= '0;
      end
      if (cmd.walk_step) begin
        anc_mark[par_q] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
    end
    if (cmd.decode) begin
      res <= res_next;
    end
    if (cmd.out_load) begin
      out_data <= res;
    end
    if (cmd.load_parent) begin
      par_mem[item.tag_id] <= item.parent_id;
    end
    if (cmd.walk_start || cmd.walk_step) begin
      par_q <= par_vld[par_raddr] ? par_mem[par_raddr] : '0;
    end
    if (cmd.add_commit) begin
      list_mem[cnt[LIST_IDX_W-1:0]] <= item.tag_id;
      pos_mem[item.tag_id]          <= cnt[LIST_IDX_W-1:0];
    end
    if (cmd.rm_commit) begin
      list_mem[pos_q]  <= list_q;
      pos_mem[list_q]  <= pos_q;
    end
    if (cmd.rm_start || cmd.tag_fetch) begin
      list_q <= list_mem[list_raddr];
    end
    if (cmd.rm_start) begin
      pos_q <= pos_mem[item.tag_id];
    end
    if (cmd.anc_clear) begin
      li <= '0;
    end else if (cmd.walk_start) begin
      li <= li + CNT_W'(1);
    end
    if (cmd.walk_start) begin
      steps <= '0;
    end else if (cmd.walk_step) begin
      steps <= steps + STEP_W'(1);
    end
  end

endmodule

[hdl/hts_controller.sv]
module hts_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hts_pkg::hts_stat_t stat,
  output hts_pkg::hts_cmd_t  cmd
);
  import hts_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_DECODE   = 8'b0000_0010,
    S_RM       = 8'b0000_0100,
    S_REBUILD  = 8'b0000_1000,
    S_NEXT_TAG = 8'b0001_0000,
    S_TAG_WAIT = 8'b0010_0000,
    S_WALK     = 8'b0100_0000,
    S_FIN      = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_FIN;
        if (stat.action == ACT_CLEAR) begin
          cmd.clear_set = 1'b1;
        end else if (!stat.tag_zero) begin
          case (stat.action)
            ACT_LOAD: cmd.load_parent = 1'b1;
            ACT_ADD: begin
              if (!stat.exp_hit && !stat.full) begin
                cmd.add_commit = 1'b1;
                state_next     = S_REBUILD;
              end
            end
            ACT_REMOVE: begin
              if (stat.exp_hit) begin
                cmd.rm_start = 1'b1;
                state_next   = S_RM;
              end
            end
            default: state_next = S_FIN;
          endcase
        end
      end
      S_RM: begin
        cmd.rm_commit = 1'b1;
        state_next    = S_REBUILD;
      end
      S_REBUILD: begin
        cmd.anc_clear = 1'b1;
        state_next    = S_NEXT_TAG;
      end
      S_NEXT_TAG: begin
        if (stat.list_done) begin
          state_next = S_FIN;
        end else begin
          cmd.tag_fetch = 1'b1;
          state_next    = S_TAG_WAIT;
        end
      end
      S_TAG_WAIT: begin
        cmd.walk_start = 1'b1;
        state_next     = S_WALK;
      end
      S_WALK: begin
        if (stat.walk_done) begin
          state_next = S_NEXT_TAG;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/hierarchical_tag_set.sv]
// Load, query, clear and refused actions are decoded and go straight to the output stage;
// an add or remove that changes the set first rebuilds the ancestor marks, walking the
// parent chain of every tag held after the change. A result waits while the output
// register still holds a stalled earlier one. The block takes one item at a time.
// Reset (synchronous, active high) empties the set, the ancestor marks and the parent
// table through per-entry valid bits; there is no clearing pass.
module hierarchical_tag_set (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  hts_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output hts_pkg::out_item_t out_data
);
  import hts_pkg::*;

  // The controller sequences each item: it decodes the action, and for an add or
  // remove that changes the set it runs the ancestor rebuild, one parent step per
  // cycle, for every tag in the explicit list.
  hts_cmd_t  cmd;
  hts_stat_t stat;

  hts_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath holds the parent table, the explicit list with its position index,
  // the explicit and ancestor marks, and the output register. The output register
  // lets a finished result wait for its transfer while the next item is accepted.
  hts_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[hdl/hts_checker.sv]
module hts_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input hts_pkg::out_item_t out_data
);
  import hts_pkg::*;

  // A held result keeps its value until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in progress");

  // A found result only comes with an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.found) |-> (out_data.status == ST_OK))
    else $error("found set with an error status");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind hierarchical_tag_set hts_checker u_chk (.*);
